### rtl/core/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared constants, item codes and helpers for the 4bpp clipping sprite
// blitter.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int unsigned SCREEN_WIDTH    = 320;
  localparam int unsigned SCREEN_HEIGHT   = 224;
  localparam int unsigned MAX_SPRITE_SIZE = 512;

  localparam int unsigned COORD_W   = 9;
  localparam int unsigned SIZE_W    = 10;
  localparam int unsigned DEST_Y_W  = 8;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned NIBBLE_W  = 4;
  localparam int unsigned PAL_DEPTH = 16;

  typedef enum logic [1:0] {
    OP_HEADER  = 2'd0,
    OP_PALETTE = 2'd1,
    OP_PIXEL   = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  // Saturate a sprite dimension to the largest supported size.
  function automatic logic [SIZE_W-1:0] size_clamp(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] lim;
    lim = SIZE_W'(MAX_SPRITE_SIZE);
    size_clamp = (v > lim) ? lim : v;
  endfunction

endpackage

### rtl/core/sprite_blitter_4bpp_clip.sv
// ----------------------------------------------------------------------------
// sprite_blitter_4bpp_clip
// Maps 4bpp source bytes of a sprite to clipped, palette-coloured screen
// pixel writes, with horizontal and vertical mirroring.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | carries
//  --------+-----------+-------------------------+-------------------------------
//  in      | sink      | in_valid_i / in_ready_o | header, palette write, pixel byte
//  out     | source    | out_valid_o/out_ready_i | dest_x, dest_y, colour, last
//
//  A pixel byte has its position mapped and both palette entries read in the
//  mapping stage (two read ports on the 16-entry palette memory), then leaves
//  one result per cycle through the output register while the output is not
//  stalled; a new byte is accepted only once the held byte's visible pixels
//  are sent. Reset clears the sprite registers, counters and valid flags;
//  the palette is not cleared. A stall on the output holds the mapping stage
//  and with it the input.
//
module sprite_blitter_4bpp_clip
  import sbc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic [COORD_W-1:0]  origin_x_in_i,
  input  logic [COORD_W-1:0]  origin_y_in_i,
  input  logic [SIZE_W-1:0]   sprite_width_i,
  input  logic [SIZE_W-1:0]   sprite_height_i,
  input  logic                mirror_x_i,
  input  logic                mirror_y_i,
  input  logic [NIBBLE_W-1:0] palette_index_i,
  input  logic [COLOR_W-1:0]  palette_color_i,
  input  logic [7:0]          pixel_pair_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [COORD_W-1:0]  dest_x_o,
  output logic [DEST_Y_W-1:0] dest_y_o,
  output logic [COLOR_W-1:0]  pixel_color_o,
  output logic                last_of_run_o
);

  // Palette memory
  logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];

  // Sprite registers and counters
  logic [COORD_W-1:0] origin_x_q, origin_y_q;
  logic [SIZE_W-1:0]  width_q, height_q;
  logic               mirror_x_q, mirror_y_q;
  logic [SIZE_W-1:0]  row_cnt_q;
  logic [COORD_W-1:0] byte_cnt_q;

  // Mapping stage
  logic               pend_a_q, pend_b_q, pend_a_d, pend_b_d;
  logic               pend_a_drn, pend_b_drn;
  logic [COORD_W-1:0] xbase_q, y_q;
  logic               fx_q;
  logic [COLOR_W-1:0] col_a_q, col_b_q;

  // Output register
  logic               out_valid_q;
  logic [COORD_W-1:0] dest_x_q;
  logic [DEST_Y_W-1:0] dest_y_q;
  logic [COLOR_W-1:0] color_q;
  logic               last_q;

  logic               in_xfer, out_free, is_pixel;
  logic [COORD_W-1:0] bpr, pair, xbase_c, y_c;
  logic [SIZE_W-1:0]  row;
  logic [SIZE_W-1:0]  byte_nxt;
  logic               active, row_end;
  logic [COORD_W-1:0] xa, xb;
  logic               y_ok, emit_a, emit_b;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign is_pixel = (operation_i == OP_PIXEL);
  assign out_free = !out_valid_q || out_ready_i;

  // Position of the incoming byte
  assign bpr      = width_q[SIZE_W-1:1];
  assign active   = (bpr != '0) && (row_cnt_q < height_q);
  assign row      = mirror_y_q ? (height_q - SIZE_W'(1) - row_cnt_q) : row_cnt_q;
  assign pair     = mirror_x_q ? (bpr - COORD_W'(1) - byte_cnt_q) : byte_cnt_q;
  assign y_c      = origin_y_q + row[COORD_W-1:0];
  assign xbase_c  = origin_x_q + {pair[COORD_W-2:0], 1'b0};
  assign byte_nxt = {1'b0, byte_cnt_q} + SIZE_W'(1);
  assign row_end  = byte_nxt >= {1'b0, bpr};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      width_q    <= '0;
      height_q   <= '0;
      mirror_x_q <= 1'b0;
      mirror_y_q <= 1'b0;
      row_cnt_q  <= '0;
      byte_cnt_q <= '0;
    end else if (in_xfer) begin
      case (operation_i)
        OP_HEADER: begin
          origin_x_q <= origin_x_in_i;
          origin_y_q <= origin_y_in_i;
          width_q    <= size_clamp(sprite_width_i);
          height_q   <= size_clamp(sprite_height_i);
          mirror_x_q <= mirror_x_i;
          mirror_y_q <= mirror_y_i;
          row_cnt_q  <= '0;
          byte_cnt_q <= '0;
        end
        OP_PIXEL: begin
          if (active) begin
            if (row_end) begin
              byte_cnt_q <= '0;
              row_cnt_q  <= row_cnt_q + SIZE_W'(1);
            end else begin
              byte_cnt_q <= byte_nxt[COORD_W-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Palette: one write port, two registered read ports for the two nibbles
  always_ff @(posedge clk_i) begin
    if (in_xfer && (operation_i == OP_PALETTE)) begin
      pal_mem[palette_index_i] <= palette_color_i;
    end
    if (in_xfer && is_pixel) begin
      col_a_q <= pal_mem[pixel_pair_i[7:4]];
      col_b_q <= pal_mem[pixel_pair_i[3:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && is_pixel) begin
      xbase_q <= xbase_c;
      y_q     <= y_c;
      fx_q    <= mirror_x_q;
    end
  end

  // Clip the held byte; mirroring swaps the nibble columns
  assign xa     = xbase_q + {{(COORD_W-1){1'b0}}, fx_q};
  assign xb     = xbase_q + {{(COORD_W-1){1'b0}}, !fx_q};
  assign y_ok   = y_q < COORD_W'(SCREEN_HEIGHT);
  assign emit_a = pend_a_q && y_ok && (xa < COORD_W'(SCREEN_WIDTH));
  assign emit_b = pend_b_q && y_ok && (xb < COORD_W'(SCREEN_WIDTH));

  always_comb begin
    pend_a_drn = pend_a_q;
    pend_b_drn = pend_b_q;
    if (out_free && emit_a) begin
      pend_a_drn = 1'b0;
      pend_b_drn = emit_b;
    end else if (!emit_a && (out_free || !emit_b)) begin
      // drop the second pixel once sent, or both when nothing is visible
      pend_a_drn = 1'b0;
      pend_b_drn = 1'b0;
    end
  end

  assign in_ready_o = !pend_a_drn && !pend_b_drn;

  always_comb begin
    pend_a_d = pend_a_drn;
    pend_b_d = pend_b_drn;
    if (in_xfer && is_pixel) begin
      pend_a_d = active && (pixel_pair_i[7:4] != '0);
      pend_b_d = active && (pixel_pair_i[3:0] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_a_q <= 1'b0;
      pend_b_q <= 1'b0;
    end else begin
      pend_a_q <= pend_a_d;
      pend_b_q <= pend_b_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit_a || emit_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      dest_y_q <= y_q[DEST_Y_W-1:0];
      if (emit_a) begin
        dest_x_q <= xa;
        color_q  <= col_a_q;
        last_q   <= !emit_b;
      end else begin
        dest_x_q <= xb;
        color_q  <= col_b_q;
        last_q   <= 1'b1;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dest_x_o      = dest_x_q;
  assign dest_y_o      = dest_y_q;
  assign pixel_color_o = color_q;
  assign last_of_run_o = last_q;

endmodule

### rtl/core/sbc_checker.sv
// ----------------------------------------------------------------------------
// sbc_checker
// Port-level checks for the sprite blitter, bound to the top level.
// ----------------------------------------------------------------------------
module sbc_checker
  import sbc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [COORD_W-1:0]  dest_x_o,
  input logic [DEST_Y_W-1:0] dest_y_o,
  input logic [COLOR_W-1:0]  pixel_color_o,
  input logic                last_of_run_o
);

  // A held transfer keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(dest_x_o)
      && $stable(dest_y_o) && $stable(pixel_color_o) && $stable(last_of_run_o))
    else $error("output transfer changed while stalled");

  // Every emitted pixel lies on screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (dest_x_o < COORD_W'(SCREEN_WIDTH))
      && (dest_y_o < DEST_Y_W'(SCREEN_HEIGHT)))
    else $error("pixel written off screen");

  // The first of a pair is followed straight away by its partner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o)
    else $error("second pixel of a byte missing");

  // Input back-pressure always has a pixel write behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> out_valid_o)
    else $error("input stalled with no pixel write following");

endmodule

bind sprite_blitter_4bpp_clip sbc_checker u_sbc_checker (.*);
